// File: design/stsp_pkg.sv
// ----------------------------------------------------------------------------
// Stanley steering pose step: shared package
// Widths, fixed-point constants, register indexes and the CORDIC arc table
// used by the pipeline units of the steering block.
// ----------------------------------------------------------------------------
package stsp_pkg;

	// Number formats.
	localparam int POS_FRAC_BITS = 16;
	localparam int ANGLE_BITS    = 16;
	localparam int ANGLE_SHIFT   = 32 - ANGLE_BITS;
	localparam int VEL_SHIFT     = 54 - POS_FRAC_BITS;
	localparam int TURN_SHIFT    = 54 - ANGLE_BITS;
	localparam int STEER_SHIFT   = 8 + ANGLE_SHIFT;

	// CORDIC datapaths.
	localparam int CORDIC_STEPS = 30;
	localparam int ROT_W        = 33;
	localparam int VEC_W        = 56;
	localparam int ZANG_W       = 33;
	localparam logic signed [ROT_W-1:0] CORDIC_GAIN = ROT_W'(652032874);

	// Turn-rate divider.
	localparam int NUM_W = 60;
	localparam int DEN_W = 47;
	localparam int QUO_W = 30;
	localparam logic [29:0] TURN_PER_RAD = 30'd683565276;

	// Steering limits and applicability bounds.
	localparam int STEER_W     = 12;
	localparam int STEER_LIM   = (9 << ANGLE_BITS) / 360;
	localparam int BEHIND_LIM  = 3 << (POS_FRAC_BITS - 1);
	localparam int QUARTER_ANG = 1 << (ANGLE_BITS - 2);

	// Configuration port.
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_GOAL_X       = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y       = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GOAL_HEADING = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEER_GAIN   = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_XTRACK_GAIN  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WHEELBASE    = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_SPEED  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 4'd7;

	// Register values after reset.
	localparam logic [15:0] RST_STEER_GAIN  = 16'd256;
	localparam logic [15:0] RST_XTRACK_GAIN = 16'd256;
	localparam logic [15:0] RST_WHEELBASE   = 16'd256;
	localparam logic [15:0] RST_DRIVE_SPEED = 16'd128;
	localparam logic [15:0] RST_TIME_STEP   = 16'd6554;

	// atan(2^-i) as a 32-bit binary angle.
	localparam logic [31:0] ARC_TABLE [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
	};

endpackage

// File: design/stsp_if.sv
// ----------------------------------------------------------------------------
// Stanley steering pose step: stream interfaces
// Valid/ready channels for the pose words going in and the result words
// coming out.
// ----------------------------------------------------------------------------
interface stsp_pose_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pose_x;
	logic signed [31:0] pose_y;
	logic [15:0]        pose_heading;

	modport source (output valid, pose_x, pose_y, pose_heading, input ready);
	modport sink   (input valid, pose_x, pose_y, pose_heading, output ready);
endinterface

interface stsp_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] next_x;
	logic signed [31:0] next_y;
	logic [15:0]        next_heading;
	logic signed [11:0] steer_angle;
	logic               applies;

	modport source (output valid, next_x, next_y, next_heading, steer_angle, applies,
		input ready);
	modport sink   (input valid, next_x, next_y, next_heading, steer_angle, applies,
		output ready);
endinterface

// File: design/stsp_cordic_rot.sv
// ----------------------------------------------------------------------------
// Stanley steering pose step: rotation CORDIC
// Pipelined sine and cosine of a 32-bit binary angle, one micro-rotation per
// register stage, Q30 results.
// ----------------------------------------------------------------------------
module stsp_cordic_rot
	import stsp_pkg::*;
(
	input  logic                    clk,
	input  logic                    en,
	input  logic [31:0]             angle,
	output logic signed [ROT_W-1:0] cos_val,
	output logic signed [ROT_W-1:0] sin_val
);

	logic signed [ROT_W-1:0] x_s  [CORDIC_STEPS];
	logic signed [ROT_W-1:0] y_s  [CORDIC_STEPS];
	logic signed [ROT_W-1:0] z_s  [CORDIC_STEPS];
	logic [CORDIC_STEPS-1:0] flip_s;

	logic signed [ROT_W-1:0] x_in [CORDIC_STEPS];
	logic signed [ROT_W-1:0] y_in [CORDIC_STEPS];
	logic signed [ROT_W-1:0] z_in [CORDIC_STEPS];
	logic signed [ROT_W-1:0] x_nx [CORDIC_STEPS];
	logic signed [ROT_W-1:0] y_nx [CORDIC_STEPS];
	logic signed [ROT_W-1:0] z_nx [CORDIC_STEPS];
	logic [CORDIC_STEPS-1:0] flip_in;
	logic [31:0]             a_adj;
	logic                    flip;

	// Fold the second and third quadrants by half a turn, then rotate.
	always_comb begin
		flip    = angle[31] ^ angle[30];
		a_adj   = {angle[31] ^ flip, angle[30:0]};
		x_in[0] = CORDIC_GAIN;
		y_in[0] = '0;
		z_in[0] = ROT_W'($signed(a_adj));
		flip_in[0] = flip;
		for (int i = 1; i < CORDIC_STEPS; i++) begin
			x_in[i]    = x_s[i-1];
			y_in[i]    = y_s[i-1];
			z_in[i]    = z_s[i-1];
			flip_in[i] = flip_s[i-1];
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (!z_in[i][ROT_W-1]) begin
				x_nx[i] = x_in[i] - (y_in[i] >>> i);
				y_nx[i] = y_in[i] + (x_in[i] >>> i);
				z_nx[i] = z_in[i] - $signed(ROT_W'(ARC_TABLE[i]));
			end else begin
				x_nx[i] = x_in[i] + (y_in[i] >>> i);
				y_nx[i] = y_in[i] - (x_in[i] >>> i);
				z_nx[i] = z_in[i] + $signed(ROT_W'(ARC_TABLE[i]));
			end
		end
	end

	// One register stage per micro-rotation.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s    <= x_nx;
			y_s    <= y_nx;
			z_s    <= z_nx;
			flip_s <= flip_in;
		end
	end

	// Undo the quadrant fold.
	assign cos_val = flip_s[CORDIC_STEPS-1] ? -x_s[CORDIC_STEPS-1] : x_s[CORDIC_STEPS-1];
	assign sin_val = flip_s[CORDIC_STEPS-1] ? -y_s[CORDIC_STEPS-1] : y_s[CORDIC_STEPS-1];

endmodule

// File: design/stsp_cordic_vec.sv
// ----------------------------------------------------------------------------
// Stanley steering pose step: vectoring CORDIC
// Pipelined arctangent of the scaled cross track error against a unit run,
// one micro-rotation per register stage, 32-bit binary angle result.
// ----------------------------------------------------------------------------
module stsp_cordic_vec
	import stsp_pkg::*;
(
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [VEC_W-1:0]  y_start,
	output logic signed [ZANG_W-1:0] angle
);

	localparam logic signed [VEC_W-1:0] X_START = VEC_W'(1) <<< (POS_FRAC_BITS + 8);

	logic signed [VEC_W-1:0]  x_s  [CORDIC_STEPS];
	logic signed [VEC_W-1:0]  y_s  [CORDIC_STEPS];
	logic signed [ZANG_W-1:0] z_s  [CORDIC_STEPS];
	logic signed [VEC_W-1:0]  x_in [CORDIC_STEPS];
	logic signed [VEC_W-1:0]  y_in [CORDIC_STEPS];
	logic signed [ZANG_W-1:0] z_in [CORDIC_STEPS];
	logic signed [VEC_W-1:0]  x_nx [CORDIC_STEPS];
	logic signed [VEC_W-1:0]  y_nx [CORDIC_STEPS];
	logic signed [ZANG_W-1:0] z_nx [CORDIC_STEPS];

	// Drive y toward zero and accumulate the angle turned through.
	always_comb begin
		x_in[0] = X_START;
		y_in[0] = y_start;
		z_in[0] = '0;
		for (int i = 1; i < CORDIC_STEPS; i++) begin
			x_in[i] = x_s[i-1];
			y_in[i] = y_s[i-1];
			z_in[i] = z_s[i-1];
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (!y_in[i][VEC_W-1]) begin
				x_nx[i] = x_in[i] + (y_in[i] >>> i);
				y_nx[i] = y_in[i] - (x_in[i] >>> i);
				z_nx[i] = z_in[i] + $signed(ZANG_W'(ARC_TABLE[i]));
			end else begin
				x_nx[i] = x_in[i] - (y_in[i] >>> i);
				y_nx[i] = y_in[i] + (x_in[i] >>> i);
				z_nx[i] = z_in[i] - $signed(ZANG_W'(ARC_TABLE[i]));
			end
		end
	end

	// One register stage per micro-rotation.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s <= x_nx;
			y_s <= y_nx;
			z_s <= z_nx;
		end
	end

	assign angle = z_s[CORDIC_STEPS-1];

endmodule

// File: design/stsp_divider.sv
// ----------------------------------------------------------------------------
// Stanley steering pose step: turn-rate divider
// Pipelined restoring division, one quotient bit per register stage. The
// numerator must be below the divisor shifted by QUO_W; this is not enforced.
// ----------------------------------------------------------------------------
module stsp_divider
	import stsp_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic [QUO_W-1:0]  quo
);

	localparam int RW = DEN_W + QUO_W;

	logic [NUM_W-1:0] rem_s  [QUO_W];
	logic [DEN_W-1:0] den_s  [QUO_W];
	logic [QUO_W-1:0] quo_s  [QUO_W];
	logic [NUM_W-1:0] rem_in [QUO_W];
	logic [DEN_W-1:0] den_in [QUO_W];
	logic [QUO_W-1:0] quo_in [QUO_W];
	logic [NUM_W-1:0] rem_nx [QUO_W];
	logic [QUO_W-1:0] quo_nx [QUO_W];
	logic [RW:0]      dsh    [QUO_W];
	logic [RW:0]      trial  [QUO_W];

	// Trial subtract of the shifted divisor, most significant bit first.
	always_comb begin
		rem_in[0] = num;
		den_in[0] = den;
		quo_in[0] = '0;
		for (int i = 1; i < QUO_W; i++) begin
			rem_in[i] = rem_s[i-1];
			den_in[i] = den_s[i-1];
			quo_in[i] = quo_s[i-1];
		end
		for (int i = 0; i < QUO_W; i++) begin
			dsh[i]    = (RW+1)'(den_in[i]) << (QUO_W - 1 - i);
			trial[i]  = (RW+1)'(rem_in[i]) - dsh[i];
			rem_nx[i] = trial[i][RW] ? rem_in[i] : NUM_W'(trial[i]);
			quo_nx[i] = {quo_in[i][QUO_W-2:0], ~trial[i][RW]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s <= rem_nx;
			den_s <= den_in;
			quo_s <= quo_nx;
		end
	end

	assign quo = quo_s[QUO_W-1];

endmodule

// File: design/stanley_steer_and_pose_step.sv
// ----------------------------------------------------------------------------
// Stanley steering pose step
// Moves a pose into the goal frame, decides whether the controller applies,
// computes clamped Stanley steering and advances a bicycle model one step.
//
//   channel  | dir | handshake     | word
//   ---------+-----+---------------+------------------------------------------
//   pose     | in  | valid/ready   | pose_x, pose_y, pose_heading
//   result   | out | valid/ready   | next_x, next_y, next_heading,
//            |     |               | steer_angle, applies
//   cfg      | in  | cfg_we        | cfg_index, cfg_data
//
// One word enters every cycle while no held result stalls the pipeline.
// A word passes three 30-stage CORDIC units in turn and a 30-stage divider.
// All stages share one enable: a result that is not taken stalls the whole
// pipeline, so pose.ready follows result.ready when the output is full.
// Reset clears the valid bits and loads the register defaults; no clear pass.
// ----------------------------------------------------------------------------
module stanley_steer_and_pose_step
	import stsp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	stsp_pose_if.sink             pose,
	stsp_result_if.source         result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int L      = CORDIC_STEPS - 1;
	localparam int SUM_W  = ZANG_W + 1;
	localparam int SP_W   = SUM_W + 17;
	localparam logic signed [37:0]   XF_LIM   = -38'(BEHIND_LIM);
	localparam logic signed [15:0]   QTR      = 16'(QUARTER_ANG);
	localparam logic signed [SP_W:0] LIM_HI   = (SP_W+1)'(STEER_LIM);
	localparam logic signed [SP_W:0] LIM_LO   = -((SP_W+1)'(STEER_LIM));
	localparam logic [31:0]          RST_VDT  = RST_DRIVE_SPEED * RST_TIME_STEP;

	typedef struct packed {
		logic [31:0] px;
		logic [31:0] py;
		logic [15:0] ph;
		logic [32:0] dx;
		logic [32:0] dy;
		logic [15:0] et;
	} a_side_t;

	typedef struct packed {
		logic        app;
		logic [31:0] x_o;
		logic [31:0] y_o;
		logic [15:0] ph;
		logic [15:0] et;
	} b_side_t;

	typedef struct packed {
		logic               app;
		logic [31:0]        x_o;
		logic [31:0]        y_o;
		logic [15:0]        ph;
		logic [STEER_W-1:0] st;
		logic               neg;
	} late_side_t;

	// Configuration registers.
	logic signed [31:0] goal_x_q, goal_y_q;
	logic [15:0]        goal_heading_q, steer_gain_q, crosstrack_gain_q;
	logic [15:0]        wheelbase_len_q, drive_speed_q, time_step_q;
	logic [31:0]        vdt_q;

	// Pipeline control.
	logic                    en;
	logic [CORDIC_STEPS-1:0] vld_a_s, vld_b_s, vld_c_s, vld_d_s;
	logic                    vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	// Input stage.
	logic signed [32:0] dx_in, dy_in;
	logic [15:0]        et_in;
	logic [31:0]        ang_goal, ang_pose;
	a_side_t            side_a_s [CORDIC_STEPS];
	logic signed [ROT_W-1:0] cg, sg, ch, sh;

	// Goal frame products and checks.
	logic signed [65:0] pcx_s1, psy_s1, psx_s1, pcy_s1, phx_s1, phy_s1;
	logic [31:0]        px_s1, py_s1;
	logic [15:0]        ph_s1, et_s1;
	logic signed [32:0] vdt_sg;
	logic signed [37:0] xf;
	logic signed [35:0] ef;
	logic [31:0]        nx, ny;
	logic               app;
	b_side_t            side_s2, side_s3, side_s4;
	logic signed [35:0] ef_s2;
	logic signed [52:0] yprod;
	logic signed [VEC_W-1:0] yv_s3;
	b_side_t            side_b_s [CORDIC_STEPS];
	logic signed [ZANG_W-1:0] z_at;

	// Steering.
	logic signed [SUM_W-1:0] sum_v;
	logic signed [SP_W-1:0]  sp_s4;
	logic signed [SP_W:0]    negp, shv;
	logic [STEER_W-1:0]      st_clamp;
	late_side_t              side_s5, side_s6, side_s7;
	late_side_t              side_c_s [CORDIC_STEPS];
	late_side_t              side_d_s [QUO_W];
	logic [31:0]             ang_steer;
	logic signed [ROT_W-1:0] cs, ss;

	// Turn rate.
	logic [ROT_W-1:0]   mag;
	logic [45:0]        mts;
	logic [30:0]        cs_pos;
	logic [15:0]        wb_nz;
	logic [NUM_W-1:0]   num_s6;
	logic [DEN_W-1:0]   den_s6;
	logic [QUO_W-1:0]   quo;
	logic [QUO_W+29:0]  tp_s7;
	logic [15:0]        dh, nh;

	// Output register.
	logic [31:0]        x_s8, y_s8;
	logic [15:0]        head_s8;
	logic [STEER_W-1:0] steer_s8;
	logic               app_s8;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q          <= '0;
			goal_y_q          <= '0;
			goal_heading_q    <= '0;
			steer_gain_q      <= RST_STEER_GAIN;
			crosstrack_gain_q <= RST_XTRACK_GAIN;
			wheelbase_len_q   <= RST_WHEELBASE;
			drive_speed_q     <= RST_DRIVE_SPEED;
			time_step_q       <= RST_TIME_STEP;
			vdt_q             <= RST_VDT;
		end else begin
			vdt_q <= drive_speed_q * time_step_q;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GOAL_X:       goal_x_q          <= cfg_data;
					REG_GOAL_Y:       goal_y_q          <= cfg_data;
					REG_GOAL_HEADING: goal_heading_q    <= cfg_data[15:0];
					REG_STEER_GAIN:   steer_gain_q      <= cfg_data[15:0];
					REG_XTRACK_GAIN:  crosstrack_gain_q <= cfg_data[15:0];
					REG_WHEELBASE:    wheelbase_len_q   <= cfg_data[15:0];
					REG_DRIVE_SPEED:  drive_speed_q     <= cfg_data[15:0];
					REG_TIME_STEP:    time_step_q       <= cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

	// One enable for every stage; the output register is the last stage.
	assign en         = !vld_s8 || result.ready;
	assign pose.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_a_s <= '0;
			vld_b_s <= '0;
			vld_c_s <= '0;
			vld_d_s <= '0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
		end else if (en) begin
			vld_a_s <= {vld_a_s[CORDIC_STEPS-2:0], pose.valid};
			vld_s1  <= vld_a_s[L];
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_b_s <= {vld_b_s[CORDIC_STEPS-2:0], vld_s3};
			vld_s4  <= vld_b_s[L];
			vld_s5  <= vld_s4;
			vld_c_s <= {vld_c_s[CORDIC_STEPS-2:0], vld_s5};
			vld_s6  <= vld_c_s[L];
			vld_d_s <= {vld_d_s[QUO_W-2:0], vld_s6};
			vld_s7  <= vld_d_s[QUO_W-1];
			vld_s8  <= vld_s7;
		end
	end

	// Offsets from the goal, heading error and the two rotation angles.
	assign dx_in    = 33'(pose.pose_x) - 33'(goal_x_q);
	assign dy_in    = 33'(pose.pose_y) - 33'(goal_y_q);
	assign et_in    = pose.pose_heading - goal_heading_q;
	assign ang_goal = 32'd0 - {goal_heading_q, {ANGLE_SHIFT{1'b0}}};
	assign ang_pose = {pose.pose_heading, {ANGLE_SHIFT{1'b0}}};

	stsp_cordic_rot u_rot_goal (
		.clk     (clk),
		.en      (en),
		.angle   (ang_goal),
		.cos_val (cg),
		.sin_val (sg)
	);

	stsp_cordic_rot u_rot_pose (
		.clk     (clk),
		.en      (en),
		.angle   (ang_pose),
		.cos_val (ch),
		.sin_val (sh)
	);

	// Word fields that ride alongside the first rotation pair.
	always_ff @(posedge clk) begin
		if (en) begin
			side_a_s[0] <= a_side_t'{px: pose.pose_x, py: pose.pose_y,
				ph: pose.pose_heading, dx: dx_in, dy: dy_in, et: et_in};
			for (int i = 1; i < CORDIC_STEPS; i++)
				side_a_s[i] <= side_a_s[i-1];
		end
	end

	// Products for the goal frame and the position increment.
	assign vdt_sg = $signed({1'b0, vdt_q});

	always_ff @(posedge clk) begin
		if (en) begin
			pcx_s1 <= cg * $signed(side_a_s[L].dx);
			psy_s1 <= sg * $signed(side_a_s[L].dy);
			psx_s1 <= sg * $signed(side_a_s[L].dx);
			pcy_s1 <= cg * $signed(side_a_s[L].dy);
			phx_s1 <= ch * vdt_sg;
			phy_s1 <= sh * vdt_sg;
			px_s1  <= side_a_s[L].px;
			py_s1  <= side_a_s[L].py;
			ph_s1  <= side_a_s[L].ph;
			et_s1  <= side_a_s[L].et;
		end
	end

	// Goal frame coordinates, applicability and the moved position.
	always_comb begin
		xf  = 38'(pcx_s1 >>> 30) - 38'(psy_s1 >>> 30);
		ef  = 36'(psx_s1 >>> 30) + 36'(pcy_s1 >>> 30);
		nx  = px_s1 + 32'(phx_s1 >>> VEL_SHIFT);
		ny  = py_s1 + 32'(phy_s1 >>> VEL_SHIFT);
		app = (xf <= XF_LIM) && ($signed(et_s1) <= QTR) && ($signed(et_s1) >= -QTR);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= b_side_t'{app: app, x_o: app ? nx : px_s1, y_o: app ? ny : py_s1,
				ph: ph_s1, et: et_s1};
			ef_s2   <= ef;
		end
	end

	// Scale the cross track error by its gain.
	assign yprod = ef_s2 * $signed({1'b0, crosstrack_gain_q});

	always_ff @(posedge clk) begin
		if (en) begin
			yv_s3   <= VEC_W'(yprod);
			side_s3 <= side_s2;
		end
	end

	stsp_cordic_vec u_atan (
		.clk     (clk),
		.en      (en),
		.y_start (yv_s3),
		.angle   (z_at)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_b_s[0] <= side_s3;
			for (int i = 1; i < CORDIC_STEPS; i++)
				side_b_s[i] <= side_b_s[i-1];
		end
	end

	// Steering sum times the overall gain.
	assign sum_v = SUM_W'(z_at) + (SUM_W'($signed(side_b_s[L].et)) <<< ANGLE_SHIFT);

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s4   <= sum_v * $signed({1'b0, steer_gain_q});
			side_s4 <= side_b_s[L];
		end
	end

	// Negate, floor to angle units and clamp.
	always_comb begin
		negp = -((SP_W+1)'(sp_s4));
		shv  = negp >>> STEER_SHIFT;
		if (shv > LIM_HI)
			st_clamp = STEER_W'(LIM_HI);
		else if (shv < LIM_LO)
			st_clamp = STEER_W'(LIM_LO);
		else
			st_clamp = STEER_W'(shv);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= late_side_t'{app: side_s4.app, x_o: side_s4.x_o, y_o: side_s4.y_o,
				ph: side_s4.ph, st: st_clamp, neg: 1'b0};
		end
	end

	assign ang_steer = 32'($signed(side_s5.st)) << ANGLE_SHIFT;

	stsp_cordic_rot u_rot_steer (
		.clk     (clk),
		.en      (en),
		.angle   (ang_steer),
		.cos_val (cs),
		.sin_val (ss)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_c_s[0] <= side_s5;
			for (int i = 1; i < CORDIC_STEPS; i++)
				side_c_s[i] <= side_c_s[i-1];
		end
	end

	// Operands of the turn-rate division.
	always_comb begin
		mag    = ss[ROT_W-1] ? ROT_W'(-ss) : ROT_W'(ss);
		mts    = mag[29:0] * time_step_q;
		cs_pos = (!cs[ROT_W-1] && (cs != '0)) ? cs[30:0] : 31'd1;
		wb_nz  = (wheelbase_len_q != '0) ? wheelbase_len_q : 16'd1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s6  <= {mts, 14'b0};
			den_s6  <= cs_pos * wb_nz;
			side_s6 <= late_side_t'{app: side_c_s[L].app, x_o: side_c_s[L].x_o,
				y_o: side_c_s[L].y_o, ph: side_c_s[L].ph, st: side_c_s[L].st,
				neg: ss[ROT_W-1]};
		end
	end

	stsp_divider u_div (
		.clk (clk),
		.en  (en),
		.num (num_s6),
		.den (den_s6),
		.quo (quo)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_d_s[0] <= side_s6;
			for (int i = 1; i < QUO_W; i++)
				side_d_s[i] <= side_d_s[i-1];
		end
	end

	// Radians to binary angle units.
	always_ff @(posedge clk) begin
		if (en) begin
			tp_s7   <= quo * TURN_PER_RAD;
			side_s7 <= side_d_s[QUO_W-1];
		end
	end

	assign dh = tp_s7[TURN_SHIFT +: ANGLE_BITS];
	assign nh = side_s7.neg ? side_s7.ph - dh : side_s7.ph + dh;

	// Output register.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s8     <= side_s7.x_o;
			y_s8     <= side_s7.y_o;
			head_s8  <= side_s7.app ? nh : side_s7.ph;
			steer_s8 <= side_s7.app ? side_s7.st : '0;
			app_s8   <= side_s7.app;
		end
	end

	assign result.valid        = vld_s8;
	assign result.next_x       = x_s8;
	assign result.next_y       = y_s8;
	assign result.next_heading = head_s8;
	assign result.steer_angle  = steer_s8;
	assign result.applies      = app_s8;

	// A word that does not apply carries no steering.
	a_no_steer: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.applies |-> result.steer_angle == '0)
		else $error("steering on a word that does not apply");

	// Applied steering stays inside the clamp.
	a_steer_lim: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.applies |->
			($signed(result.steer_angle) <= STEER_LIM) &&
			($signed(result.steer_angle) >= -STEER_LIM))
		else $error("steering outside the clamp");

	// A held result stops the whole pipeline.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !pose.ready)
		else $error("pose taken while the result is held");

endmodule

// File: tb/sv/stanley_steer_and_pose_step_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stanley steering pose step: self-checking testbench
// Feeds pose words through the steering block under several register
// settings, predicts every result word with a bit-exact fixed-point model
// of the goal-frame test, the steering law and the bicycle step, and
// compares the result stream in order while both sides idle at random.
// ----------------------------------------------------------------------------
module stanley_steer_and_pose_step_test;
	import stsp_pkg::*;

	typedef struct {
		logic signed [31:0] next_x;
		logic signed [31:0] next_y;
		logic [15:0]        next_heading;
		logic signed [11:0] steer_angle;
		logic               applies;
	} step_word_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [15:0]        heading;
	} pose_word_t;

	localparam int HOLD_CYCLES = 400;
	localparam int RUN_LIMIT   = 300000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	stsp_pose_if   pose_ch();
	stsp_result_if result_ch();

	stanley_steer_and_pose_step i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pose      (pose_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Local copy of the register file used by the predictor.
	logic signed [31:0] goal_x_q, goal_y_q;
	logic [15:0] goal_hdg_q, steer_gain_q, xtrack_gain_q, wheelbase_q, speed_q, dt_q;

	pose_word_t pose_pending[$];
	step_word_t step_expected[$];
	int  mismatches;
	int  cycles;
	bit  quiet;
	bit  hold_req;
	int  hold_cnt;
	int  pose_gap;
	int  res_gap;
	logic pose_acc;
	logic res_acc;

	// Clock.
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Rotation CORDIC on a 32-bit binary angle, Q30 cosine and sine.
	function automatic void rotate_angle(input bit [31:0] ang, output longint c,
		output longint s);
		longint x, y, z, tx, ty;
		bit flip;
		flip = ang[31] ^ ang[30];
		if (flip)
			ang = ang + 32'h80000000;
		x = 652032874;
		y = 0;
		z = longint'($signed(ang));
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			tx = y >>> i;
			ty = x >>> i;
			if (z >= 0) begin
				x -= tx; y += ty; z -= longint'(ARC_TABLE[i]);
			end else begin
				x += tx; y -= ty; z += longint'(ARC_TABLE[i]);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	// Vectoring CORDIC: angle of (x, y) as a 32-bit binary angle.
	function automatic longint vector_angle(input longint x, input longint y);
		longint z, tx, ty;
		z = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			tx = y >>> i;
			ty = x >>> i;
			if (y >= 0) begin
				x += tx; y -= ty; z += longint'(ARC_TABLE[i]);
			end else begin
				x -= tx; y += ty; z -= longint'(ARC_TABLE[i]);
			end
		end
		return z;
	endfunction

	// Steering and one bicycle step for one pose.
	function automatic step_word_t steer_step(input pose_word_t p);
		step_word_t w;
		longint px, py, dx, dy, cg, sg, xf, ef, et, z, sum, st, ch, sh, cs, ss;
		longint unsigned vdt, mag, den, r, dh, wb;
		px = p.x;
		py = p.y;
		w.next_x = p.x;
		w.next_y = p.y;
		w.next_heading = p.heading;
		w.steer_angle = '0;
		w.applies = 1'b0;
		dx = px - longint'(goal_x_q);
		dy = py - longint'(goal_y_q);
		rotate_angle(32'(0) - {goal_hdg_q, 16'h0}, cg, sg);
		xf = ((cg * dx) >>> 30) - ((sg * dy) >>> 30);
		ef = ((sg * dx) >>> 30) + ((cg * dy) >>> 30);
		if (xf > -longint'(BEHIND_LIM))
			return w;
		et = longint'(16'(p.heading - goal_hdg_q));
		if (et >= 32768)
			et -= 65536;
		if (et > QUARTER_ANG || et < -QUARTER_ANG)
			return w;
		z = vector_angle(longint'(1) << 24, longint'(xtrack_gain_q) * ef);
		sum = z + et * 65536;
		st = (-(longint'(steer_gain_q) * sum)) >>> STEER_SHIFT;
		if (st > STEER_LIM)
			st = STEER_LIM;
		if (st < -STEER_LIM)
			st = -STEER_LIM;
		rotate_angle({p.heading, 16'h0}, ch, sh);
		vdt = longint'(speed_q) * longint'(dt_q);
		w.next_x = 32'(px + ((ch * longint'(vdt)) >>> VEL_SHIFT));
		w.next_y = 32'(py + ((sh * longint'(vdt)) >>> VEL_SHIFT));
		rotate_angle(32'(st) << 16, cs, ss);
		wb = (wheelbase_q == 0) ? 1 : wheelbase_q;
		mag = (ss < 0) ? -ss : ss;
		den = ((cs > 0) ? cs : 1) * wb;
		r = ((mag * dt_q) << 14) / den;
		dh = (r * 683565276) >> TURN_SHIFT;
		w.next_heading = (ss < 0) ? 16'(p.heading - dh) : 16'(p.heading + dh);
		w.steer_angle = 12'(st);
		w.applies = 1'b1;
		return w;
	endfunction

	// Register write; the enable is lowered by the caller after the last one.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_GOAL_X:       goal_x_q = val;
			REG_GOAL_Y:       goal_y_q = val;
			REG_GOAL_HEADING: goal_hdg_q = val[15:0];
			REG_STEER_GAIN:   steer_gain_q = val[15:0];
			REG_XTRACK_GAIN:  xtrack_gain_q = val[15:0];
			REG_WHEELBASE:    wheelbase_q = val[15:0];
			REG_DRIVE_SPEED:  speed_q = val[15:0];
			REG_TIME_STEP:    dt_q = val[15:0];
			default: ;
		endcase
	endtask

	task automatic add_pose(input logic [31:0] x, input logic [31:0] y,
		input logic [15:0] h);
		pose_word_t p;
		p.x = x;
		p.y = y;
		p.heading = h;
		pose_pending.push_back(p);
	endtask

	// Waits until every pose is taken and every result word has come back.
	task automatic drain();
		do @(posedge clk);
		while (pose_pending.size() != 0 || pose_ch.valid || step_expected.size() != 0);
	endtask

	// Pose driver: holds a word until taken, then idles a drawn number of cycles.
	always @(negedge clk) begin
		pose_word_t p;
		if (!arst_n) begin
			pose_ch.valid <= 1'b0;
		end else if (pose_ch.valid && !pose_acc) begin
			pose_ch.valid <= 1'b1;
		end else if (pose_gap > 0) begin
			pose_gap--;
			pose_ch.valid <= 1'b0;
		end else if (pose_pending.size() != 0) begin
			p = pose_pending.pop_front();
			pose_ch.pose_x <= p.x;
			pose_ch.pose_y <= p.y;
			pose_ch.pose_heading <= p.heading;
			pose_ch.valid <= 1'b1;
			pose_gap = quiet ? 0 : $urandom_range(0, 6);
		end else begin
			pose_ch.valid <= 1'b0;
		end
	end

	// Result receiver: random back-pressure plus an occasional long hold.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = HOLD_CYCLES;
		end
		if (res_acc && !quiet)
			res_gap = $urandom_range(0, 6);
		if (hold_cnt > 0) begin
			hold_cnt--;
			result_ch.ready <= 1'b0;
		end else if (res_gap > 0) begin
			res_gap--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= arst_n;
		end
	end

	// Input side: every accepted pose word gets its predicted result.
	always @(posedge clk) begin
		pose_word_t p;
		pose_acc <= pose_ch.valid && pose_ch.ready;
		if (arst_n && pose_ch.valid && pose_ch.ready) begin
			p.x = pose_ch.pose_x;
			p.y = pose_ch.pose_y;
			p.heading = pose_ch.pose_heading;
			step_expected.push_back(steer_step(p));
		end
	end

	// Output side: compare each result word with the oldest prediction.
	always @(posedge clk) begin
		step_word_t e;
		res_acc <= result_ch.valid && result_ch.ready;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (step_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result word with nothing expected at %0t", $realtime);
			end else begin
				e = step_expected.pop_front();
				if (result_ch.next_x !== e.next_x || result_ch.next_y !== e.next_y
					|| result_ch.next_heading !== e.next_heading
					|| result_ch.steer_angle !== e.steer_angle
					|| result_ch.applies !== e.applies) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch at %0t: expected x=%h y=%h h=%h st=%h ap=%b, got x=%h y=%h h=%h st=%h ap=%b",
							$realtime, e.next_x, e.next_y, e.next_heading, e.steer_angle,
							e.applies, result_ch.next_x, result_ch.next_y,
							result_ch.next_heading, result_ch.steer_angle,
							result_ch.applies);
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("stanley_steer_and_pose_step_test NOT OK");
			$finish;
		end
	end

	// Stimulus: directed poses at reset settings, then random phases.
	initial begin
		logic [31:0] lo [8];
		logic [31:0] hi [8];
		logic [31:0] v;
		logic [31:0] gx, gy;
		int r;
		lo = '{32'h80000000, 32'h80000000, 0, 0, 0, 1, 0, 1};
		hi = '{32'h7fffffff, 32'h7fffffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
			16'hffff, 16'hffff};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pose_ch.valid = 1'b0;
		pose_ch.pose_x = '0;
		pose_ch.pose_y = '0;
		pose_ch.pose_heading = '0;
		result_ch.ready = 1'b0;
		mismatches = 0;
		cycles = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		hold_cnt = 0;
		pose_gap = 0;
		res_gap = 0;
		pose_acc = 1'b0;
		res_acc = 1'b0;
		goal_x_q = '0;
		goal_y_q = '0;
		goal_hdg_q = '0;
		steer_gain_q = RST_STEER_GAIN;
		xtrack_gain_q = RST_XTRACK_GAIN;
		wheelbase_q = RST_WHEELBASE;
		speed_q = RST_DRIVE_SPEED;
		dt_q = RST_TIME_STEP;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed poses: distance and heading-error boundaries, field extremes.
		add_pose(-32'sd98304, 0, 0);
		add_pose(-32'sd98303, 0, 0);
		add_pose(-32'sd200000, 32'sd50000, 16384);
		add_pose(-32'sd200000, -32'sd50000, 49152);
		add_pose(-32'sd200000, 0, 16385);
		add_pose(-32'sd200000, 0, 49151);
		add_pose(-32'sd200000, 0, 32768);
		add_pose(32'h80000000, 32'h7fffffff, 16'hffff);
		add_pose(32'h80000000, 32'h80000000, 0);
		add_pose(32'h7fffffff, 32'h80000000, 16'hffff);
		add_pose(-32'sd98304, 32'h7fffffff, 16'h0001);
		add_pose(-32'sd98304, 32'h80000000, 16'hffff);
		add_pose(-32'sd1000000, 32'sd3000000, 200);
		add_pose(-32'sd1000000, -32'sd3000000, 65000);
		add_pose(0, 0, 0);
		add_pose(32'hffffffff, 32'hffffffff, 16'h8000);
		drain();

		// Random phases: extremes first, then mixed settings.
		for (int ph = 1; ph <= 8; ph++) begin
			for (int k = 0; k < 8; k++) begin
				if (ph == 1)
					v = lo[k];
				else if (ph == 2)
					v = hi[k];
				else if (k == 5 || k == 7)
					v = $urandom_range(1, 65535);
				else if (k >= 2)
					v = ($urandom_range(0, 3) == 0) ? hi[k] : $urandom_range(0, 2048);
				else
					v = $urandom;
				write_reg(CFG_IDX_W'(k), v);
			end
			if (ph == 3) begin
				write_reg(4'd8, $urandom);
				write_reg(4'd15, $urandom);
			end
			@(negedge clk);
			cfg_we <= 1'b0;
			quiet = (ph == 5);
			if (ph == 4) begin
				@(posedge clk);
				hold_req = 1'b1;
			end
			gx = goal_x_q;
			gy = goal_y_q;
			for (int n = 0; n < 112; n++) begin
				r = $urandom_range(0, 9);
				if (r < 2)
					add_pose($urandom, $urandom, $urandom);
				else
					add_pose(gx + 32'($signed($urandom_range(0, 32'h00800000)) - 32'sh400000),
						gy + 32'($signed($urandom_range(0, 32'h00800000)) - 32'sh400000),
						goal_hdg_q + 16'($urandom_range(0, 40000) - 20000));
			end
			drain();
		end

		repeat (200) @(posedge clk);
		if (mismatches == 0 && step_expected.size() == 0)
			$display("stanley_steer_and_pose_step_test OK");
		else
			$display("stanley_steer_and_pose_step_test NOT OK");
		$finish;
	end

endmodule
